FILE: hw/rtl/gce_pkg.sv
// Shared types, register offsets, codes and reset constants of the GPIO event detect core.
// No dependencies; every other file of the core refers to it by scoped names.

package gce_pkg;

    localparam int PIN_COUNT_DEF  = 58;
    localparam int PULL_REG_COUNT = 4;

    localparam int FSEL_REG_COUNT = 6;
    localparam int FSEL_PER_REG   = 10;
    localparam int FSEL_PINS      = FSEL_REG_COUNT * FSEL_PER_REG;
    localparam int DET_KINDS      = 6;
    localparam int PULL3_BITS     = 20;
    localparam int SD_FIRST_PIN   = 48;
    localparam int SD_LAST_PIN    = 53;

    // Item functions.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_PIN   = 2'd2;

    // Access error codes.
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
    localparam logic [1:0] ERR_DIRECTION = 2'd2;

    // Pin function codes.
    localparam logic [2:0] FSEL_INPUT  = 3'd0;
    localparam logic [2:0] FSEL_OUTPUT = 3'd1;
    localparam logic [2:0] FSEL_ALT0   = 3'd4;

    // Detector kinds.
    localparam logic [2:0] KIND_RISE  = 3'd0;
    localparam logic [2:0] KIND_FALL  = 3'd1;
    localparam logic [2:0] KIND_HIGH  = 3'd2;
    localparam logic [2:0] KIND_LOW   = 3'd3;
    localparam logic [2:0] KIND_ARISE = 3'd4;
    localparam logic [2:0] KIND_AFALL = 3'd5;

    // Register word offsets (byte offset divided by four).
    localparam logic [5:0] W_FSEL0 = 6'd0;
    localparam logic [5:0] W_FSEL1 = 6'd1;
    localparam logic [5:0] W_FSEL2 = 6'd2;
    localparam logic [5:0] W_FSEL3 = 6'd3;
    localparam logic [5:0] W_FSEL4 = 6'd4;
    localparam logic [5:0] W_FSEL5 = 6'd5;
    localparam logic [5:0] W_SET0  = 6'd7;
    localparam logic [5:0] W_SET1  = 6'd8;
    localparam logic [5:0] W_CLR0  = 6'd10;
    localparam logic [5:0] W_CLR1  = 6'd11;
    localparam logic [5:0] W_LEV0  = 6'd13;
    localparam logic [5:0] W_LEV1  = 6'd14;
    localparam logic [5:0] W_EDS0  = 6'd16;
    localparam logic [5:0] W_EDS1  = 6'd17;
    localparam logic [5:0] W_REN0  = 6'd19;
    localparam logic [5:0] W_REN1  = 6'd20;
    localparam logic [5:0] W_FEN0  = 6'd22;
    localparam logic [5:0] W_FEN1  = 6'd23;
    localparam logic [5:0] W_HEN0  = 6'd25;
    localparam logic [5:0] W_HEN1  = 6'd26;
    localparam logic [5:0] W_LEN0  = 6'd28;
    localparam logic [5:0] W_LEN1  = 6'd29;
    localparam logic [5:0] W_AREN0 = 6'd31;
    localparam logic [5:0] W_AREN1 = 6'd32;
    localparam logic [5:0] W_AFEN0 = 6'd34;
    localparam logic [5:0] W_AFEN1 = 6'd35;
    localparam logic [5:0] W_PUD0  = 6'd57;
    localparam logic [5:0] W_PUD1  = 6'd58;
    localparam logic [5:0] W_PUD2  = 6'd59;
    localparam logic [5:0] W_PUD3  = 6'd60;

    localparam logic [31:0] IRQ_BANK0_MASK     = 32'h0fff_ffff;
    localparam logic [31:0] IRQ_BANK1_LOW_MASK = 32'h0000_3fff;
    localparam logic [31:0] IRQ_BANK2_MASK     = 32'h03ff_c000;

    localparam logic [31:0]           PULL_RESET0 = 32'haaa9_5555;
    localparam logic [31:0]           PULL_RESET1 = 32'ha0aa_aaaa;
    localparam logic [31:0]           PULL_RESET2 = 32'h50aa_a95a;
    localparam logic [PULL3_BITS-1:0] PULL_RESET3 = 20'h5_5555;

    typedef enum logic [2:0] {
        RC_FSEL,
        RC_SET,
        RC_CLR,
        RC_LEV,
        RC_EDS,
        RC_DET,
        RC_PULL,
        RC_NONE
    } reg_class_t;

    // idx is the FSEL word, the detector kind or the pull word, by class.
    typedef struct packed {
        reg_class_t cls;
        logic       bank;
        logic [2:0] idx;
    } reg_dec_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  reg_word;
        logic [31:0] write_data;
        logic [5:0]  pin_index;
        logic        pin_level;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
        logic        sd_host_selected;
        logic [1:0]  access_error;
    } result_t;

    function automatic reg_dec_t decode_reg(input logic [5:0] w);
        reg_dec_t d;
        d.cls  = RC_NONE;
        d.bank = 1'b0;
        d.idx  = 3'd0;
        case (w)
            W_FSEL0, W_FSEL1, W_FSEL2, W_FSEL3, W_FSEL4, W_FSEL5:
            begin
                d.cls = RC_FSEL;
                d.idx = w[2:0];
            end
            W_SET0: d.cls = RC_SET;
            W_SET1:
            begin
                d.cls  = RC_SET;
                d.bank = 1'b1;
            end
            W_CLR0: d.cls = RC_CLR;
            W_CLR1:
            begin
                d.cls  = RC_CLR;
                d.bank = 1'b1;
            end
            W_LEV0: d.cls = RC_LEV;
            W_LEV1:
            begin
                d.cls  = RC_LEV;
                d.bank = 1'b1;
            end
            W_EDS0: d.cls = RC_EDS;
            W_EDS1:
            begin
                d.cls  = RC_EDS;
                d.bank = 1'b1;
            end
            W_REN0, W_REN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_RISE;
                d.bank = (w == W_REN1);
            end
            W_FEN0, W_FEN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_FALL;
                d.bank = (w == W_FEN1);
            end
            W_HEN0, W_HEN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_HIGH;
                d.bank = (w == W_HEN1);
            end
            W_LEN0, W_LEN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_LOW;
                d.bank = (w == W_LEN1);
            end
            W_AREN0, W_AREN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_ARISE;
                d.bank = (w == W_AREN1);
            end
            W_AFEN0, W_AFEN1:
            begin
                d.cls  = RC_DET;
                d.idx  = KIND_AFALL;
                d.bank = (w == W_AFEN1);
            end
            W_PUD0, W_PUD1, W_PUD2, W_PUD3:
            begin
                d.cls = RC_PULL;
                d.idx = 3'(w - W_PUD0);
            end
            default: d.cls = RC_NONE;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/gce_in_stage.sv
// Input register of the GPIO event detect core: holds one accepted word for the execute step.
// Uses gce_pkg for the item type.

module gce_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  gce_pkg::item_t item_in,
    input  logic           advance,
    output logic           stage_valid,
    output gce_pkg::item_t stage_item
);

    logic           valid_reg;
    logic           valid_next;
    gce_pkg::item_t item_reg;
    logic           accept;

    assign item_ready = !valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

FILE: hw/rtl/gce_state.sv
// Register state of the GPIO event detect core and the single-pass logic that executes one word.
// Uses gce_pkg for offsets, codes, reset constants and the item and result types.

module gce_state
#(
    parameter int PIN_COUNT = gce_pkg::PIN_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 exec_en,
    input  gce_pkg::item_t       item,
    output gce_pkg::result_t     result,
    output logic [PIN_COUNT-1:0] pin_outputs
);

    localparam int FSEL_PINS = gce_pkg::FSEL_PINS;
    localparam int DET_KINDS = gce_pkg::DET_KINDS;

    logic [2:0]           fsel_reg [FSEL_PINS];
    wire  [2:0]           fsel_next [FSEL_PINS];
    logic [PIN_COUNT-1:0] latch_reg, latch_next;
    logic [PIN_COUNT-1:0] level_in_reg, level_in_next;
    logic [PIN_COUNT-1:0] status_reg, status_next;
    logic [PIN_COUNT-1:0] det_reg [DET_KINDS];
    logic [PIN_COUNT-1:0] det_next [DET_KINDS];
    logic [31:0]          pull_reg [3];
    logic [31:0]          pull_next [3];
    logic [gce_pkg::PULL3_BITS-1:0] pull3_reg, pull3_next;
    logic                 sd_reg, sd_next;

    gce_pkg::reg_dec_t    dec;
    logic                 is_wr;
    logic                 fsel_wr;
    logic                 pin_ok;

    wire  [31:0]          fsel_word [gce_pkg::FSEL_REG_COUNT];
    wire  [63:0]          om_cur;
    wire  [63:0]          om_nxt;

    logic [63:0]          lat64, inl64, sts64;
    logic [63:0]          det64 [DET_KINDS];
    logic [63:0]          lvl_cur64;
    logic [63:0]          lat_w64, inl_w64, sts_w64;
    logic [63:0]          det_w64 [DET_KINDS];
    logic [63:0]          lat_n64, inl_n64, lvl_nxt64;
    logic [63:0]          den [DET_KINDS];
    logic [63:0]          rise64, fall64, ev64, do_mask, sts_n64;
    logic [1:0]           do_ev;
    logic [31:0]          rd;
    logic [1:0]           err;
    logic                 sd_all_in, sd_all_alt;
    logic [31:0]          ev0, ev1;

    function automatic logic [31:0] bank_word(input logic [63:0] v, input logic bank);
        return bank ? v[63:32] : v[31:0];
    endfunction

    assign dec     = gce_pkg::decode_reg(item.reg_word);
    assign is_wr   = (item.func == gce_pkg::FUNC_WRITE);
    assign fsel_wr = is_wr && (dec.cls == gce_pkg::RC_FSEL);
    assign pin_ok  = ({1'b0, item.pin_index} < 7'(PIN_COUNT));

    // Function select: fields of pins beyond the pin count are never written.
    genvar gp, gr, gi;
    generate
        for (gp = 0; gp < FSEL_PINS; gp++)
        begin : g_fsel
            localparam int FR = gp / gce_pkg::FSEL_PER_REG;
            localparam int FF = gp % gce_pkg::FSEL_PER_REG;
            if (gp < PIN_COUNT)
            begin : g_live
                assign fsel_next[gp] = (fsel_wr && dec.idx == 3'(FR)) ?
                                       item.write_data[3*FF +: 3] : fsel_reg[gp];
            end
            else
            begin : g_dead
                assign fsel_next[gp] = fsel_reg[gp];
            end
        end
        for (gp = 0; gp < 64; gp++)
        begin : g_om
            if (gp < FSEL_PINS)
            begin : g_sel
                assign om_cur[gp] = (fsel_reg[gp] == gce_pkg::FSEL_OUTPUT);
                assign om_nxt[gp] = (fsel_next[gp] == gce_pkg::FSEL_OUTPUT);
            end
            else
            begin : g_none
                assign om_cur[gp] = 1'b0;
                assign om_nxt[gp] = 1'b0;
            end
        end
        for (gr = 0; gr < gce_pkg::FSEL_REG_COUNT; gr++)
        begin : g_fword
            for (gi = 0; gi < gce_pkg::FSEL_PER_REG; gi++)
            begin : g_field
                assign fsel_word[gr][3*gi +: 3] = fsel_reg[gr*gce_pkg::FSEL_PER_REG + gi];
            end
            assign fsel_word[gr][31:3*gce_pkg::FSEL_PER_REG] = '0;
        end
    endgenerate

    // Decode and apply the register access or pin change to wide bank views.
    always_comb
    begin
        lat64 = 64'(latch_reg);
        inl64 = 64'(level_in_reg);
        sts64 = 64'(status_reg);
        for (int k = 0; k < DET_KINDS; k++)
        begin
            det64[k]   = 64'(det_reg[k]);
            det_w64[k] = det64[k];
        end
        lvl_cur64 = (lat64 & om_cur) | (inl64 & ~om_cur);
        lat_w64   = lat64;
        inl_w64   = inl64;
        sts_w64   = sts64;
        for (int k = 0; k < 3; k++)
        begin
            pull_next[k] = pull_reg[k];
        end
        pull3_next = pull3_reg;
        do_ev      = 2'b00;
        rd         = '0;
        err        = gce_pkg::ERR_OK;
        case (item.func)
            gce_pkg::FUNC_READ:
            begin
                case (dec.cls)
                    gce_pkg::RC_FSEL: rd = fsel_word[dec.idx];
                    gce_pkg::RC_SET,
                    gce_pkg::RC_CLR:  err = gce_pkg::ERR_DIRECTION;
                    gce_pkg::RC_LEV:  rd = bank_word(lvl_cur64, dec.bank);
                    gce_pkg::RC_EDS:  rd = bank_word(sts64, dec.bank);
                    gce_pkg::RC_DET:  rd = bank_word(det64[dec.idx], dec.bank);
                    gce_pkg::RC_PULL:
                    begin
                        if (dec.idx[1:0] == 2'd3)
                        begin
                            rd = 32'(pull3_reg);
                        end
                        else
                        begin
                            rd = pull_reg[dec.idx[1:0]];
                        end
                    end
                    default: err = gce_pkg::ERR_UNKNOWN;
                endcase
            end
            gce_pkg::FUNC_WRITE:
            begin
                case (dec.cls)
                    gce_pkg::RC_FSEL: do_ev = 2'b11;
                    gce_pkg::RC_SET:
                    begin
                        if (dec.bank)
                        begin
                            lat_w64[63:32] = lat64[63:32] | item.write_data;
                        end
                        else
                        begin
                            lat_w64[31:0] = lat64[31:0] | item.write_data;
                        end
                        do_ev[dec.bank] = 1'b1;
                    end
                    gce_pkg::RC_CLR:
                    begin
                        if (dec.bank)
                        begin
                            lat_w64[63:32] = lat64[63:32] & ~item.write_data;
                        end
                        else
                        begin
                            lat_w64[31:0] = lat64[31:0] & ~item.write_data;
                        end
                        do_ev[dec.bank] = 1'b1;
                    end
                    gce_pkg::RC_LEV: err = gce_pkg::ERR_DIRECTION;
                    gce_pkg::RC_EDS:
                    begin
                        if (dec.bank)
                        begin
                            sts_w64[63:32] = sts64[63:32] & ~item.write_data;
                        end
                        else
                        begin
                            sts_w64[31:0] = sts64[31:0] & ~item.write_data;
                        end
                        do_ev[dec.bank] = 1'b1;
                    end
                    gce_pkg::RC_DET:
                    begin
                        if (dec.bank)
                        begin
                            det_w64[dec.idx][63:32] = item.write_data;
                        end
                        else
                        begin
                            det_w64[dec.idx][31:0] = item.write_data;
                        end
                        // Level detectors are re-applied as soon as they are enabled.
                        if (dec.idx == gce_pkg::KIND_HIGH || dec.idx == gce_pkg::KIND_LOW)
                        begin
                            do_ev[dec.bank] = 1'b1;
                        end
                    end
                    gce_pkg::RC_PULL:
                    begin
                        if (dec.idx[1:0] == 2'd3)
                        begin
                            pull3_next = item.write_data[gce_pkg::PULL3_BITS-1:0];
                        end
                        else
                        begin
                            pull_next[dec.idx[1:0]] = item.write_data;
                        end
                    end
                    default: err = gce_pkg::ERR_UNKNOWN;
                endcase
            end
            gce_pkg::FUNC_PIN:
            begin
                if (pin_ok)
                begin
                    inl_w64[item.pin_index] = item.pin_level;
                    do_ev[item.pin_index[5]] = 1'b1;
                end
            end
            default:
            begin
                err = gce_pkg::ERR_OK;
            end
        endcase
    end

    // Bits of pins beyond the pin count are dropped here.
    always_comb
    begin
        latch_next    = lat_w64[PIN_COUNT-1:0];
        level_in_next = inl_w64[PIN_COUNT-1:0];
        for (int k = 0; k < DET_KINDS; k++)
        begin
            det_next[k] = det_w64[k][PIN_COUNT-1:0];
        end
    end

    // Event latching from the old and new pin levels, both taken from truncated state.
    always_comb
    begin
        lat_n64 = 64'(latch_next);
        inl_n64 = 64'(level_in_next);
        for (int k = 0; k < DET_KINDS; k++)
        begin
            den[k] = 64'(det_next[k]);
        end
        lvl_nxt64 = (lat_n64 & om_nxt) | (inl_n64 & ~om_nxt);
        rise64    = ~lvl_cur64 & lvl_nxt64;
        fall64    = lvl_cur64 & ~lvl_nxt64;
        ev64      = (rise64 & (den[gce_pkg::KIND_RISE] | den[gce_pkg::KIND_ARISE]))
                  | (fall64 & (den[gce_pkg::KIND_FALL] | den[gce_pkg::KIND_AFALL]))
                  | (lvl_nxt64 & den[gce_pkg::KIND_HIGH])
                  | (~lvl_nxt64 & den[gce_pkg::KIND_LOW]);
        do_mask   = {{32{do_ev[1]}}, {32{do_ev[0]}}};
        sts_n64   = sts_w64 | (ev64 & do_mask);
        status_next = sts_n64[PIN_COUNT-1:0];
    end

    // SD routing follows the function select of its six pins after each FSEL write.
    always_comb
    begin
        sd_all_in  = 1'b1;
        sd_all_alt = 1'b1;
        for (int p = gce_pkg::SD_FIRST_PIN; p <= gce_pkg::SD_LAST_PIN; p++)
        begin
            sd_all_in  = sd_all_in && (fsel_next[p] == gce_pkg::FSEL_INPUT);
            sd_all_alt = sd_all_alt && (fsel_next[p] == gce_pkg::FSEL_ALT0);
        end
        sd_next = sd_reg;
        if (fsel_wr)
        begin
            sd_next = sd_reg ? !sd_all_in : sd_all_alt;
        end
    end

    always_comb
    begin
        ev0 = sts_n64[31:0];
        ev1 = sts_n64[63:32];
        result.read_data        = rd;
        result.irq_lines[0]     = |(ev0 & gce_pkg::IRQ_BANK0_MASK);
        result.irq_lines[1]     = |(ev0 & ~gce_pkg::IRQ_BANK0_MASK)
                                | |(ev1 & gce_pkg::IRQ_BANK1_LOW_MASK);
        result.irq_lines[2]     = |(ev1 & gce_pkg::IRQ_BANK2_MASK);
        result.irq_lines[3]     = |sts_n64;
        result.sd_host_selected = sd_next;
        result.access_error     = err;
        pin_outputs             = latch_next & om_nxt[PIN_COUNT-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < FSEL_PINS; p++)
            begin
                fsel_reg[p] <= gce_pkg::FSEL_INPUT;
            end
            latch_reg    <= '0;
            level_in_reg <= '0;
            status_reg   <= '0;
            for (int k = 0; k < DET_KINDS; k++)
            begin
                det_reg[k] <= '0;
            end
            pull_reg[0] <= gce_pkg::PULL_RESET0;
            pull_reg[1] <= gce_pkg::PULL_RESET1;
            pull_reg[2] <= gce_pkg::PULL_RESET2;
            pull3_reg   <= gce_pkg::PULL_RESET3;
            sd_reg      <= 1'b0;
        end
        else if (exec_en)
        begin
            for (int p = 0; p < FSEL_PINS; p++)
            begin
                fsel_reg[p] <= fsel_next[p];
            end
            latch_reg    <= latch_next;
            level_in_reg <= level_in_next;
            status_reg   <= status_next;
            for (int k = 0; k < DET_KINDS; k++)
            begin
                det_reg[k] <= det_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                pull_reg[k] <= pull_next[k];
            end
            pull3_reg <= pull3_next;
            sd_reg    <= sd_next;
        end
    end

endmodule

FILE: hw/rtl/gpio_controller_event_detect_core.sv
// Top level of the GPIO event detect core: input stage, state and execute logic, result register.
// Depends on gce_pkg, gce_in_stage and gce_state.
//
// Usage: each input word is a register read, a register write or a change of one
// external pin level, offered on item_valid/item_ready with its fields on func,
// reg_word, write_data, pin_index and pin_level. Every word produces exactly one
// result word on result_valid/result_ready: read_data, irq_lines, pin_outputs,
// sd_host_selected and access_error, all reflecting the state after that word.
// A word is registered at acceptance, executed against the register state once the
// result register is free or being emptied, and written to the result register.
// One word is accepted per cycle while the receiver takes every result; the execute
// step is a single pass over the flop state. When the receiver stalls, the result
// register holds its word and the input register keeps one more; then item_ready
// drops until the result is taken. Reset clears all pin functions, latches, input
// levels, status and enables, loads the pull-control defaults and leaves the SD
// pins deselected from the host interface controller (sd_host_selected low).

module gpio_controller_event_detect_core
#(
    parameter int PIN_COUNT = gce_pkg::PIN_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           func,
    input  logic [5:0]           reg_word,
    input  logic [31:0]          write_data,
    input  logic [5:0]           pin_index,
    input  logic                 pin_level,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [31:0]          read_data,
    output logic [3:0]           irq_lines,
    output logic [PIN_COUNT-1:0] pin_outputs,
    output logic                 sd_host_selected,
    output logic [1:0]           access_error
);

    gce_pkg::item_t       item_in;
    gce_pkg::item_t       stage_item;
    gce_pkg::result_t     exec_result;
    gce_pkg::result_t     result_reg;
    logic [PIN_COUNT-1:0] exec_pins;
    logic [PIN_COUNT-1:0] pins_reg;
    logic                 stage_valid;
    logic                 advance;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign item_in.func       = func;
    assign item_in.reg_word   = reg_word;
    assign item_in.write_data = write_data;
    assign item_in.pin_index  = pin_index;
    assign item_in.pin_level  = pin_level;

    // The staged word executes once the result register is free or being emptied.
    assign advance = stage_valid && (!out_valid_reg || result_ready);

    gce_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    gce_state #(
        .PIN_COUNT (PIN_COUNT)
    ) u_state
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .exec_en     (advance),
        .item        (stage_item),
        .result      (exec_result),
        .pin_outputs (exec_pins)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= exec_result;
            pins_reg   <= exec_pins;
        end
    end

    assign result_valid     = out_valid_reg;
    assign read_data        = result_reg.read_data;
    assign irq_lines        = result_reg.irq_lines;
    assign pin_outputs      = pins_reg;
    assign sd_host_selected = result_reg.sd_host_selected;
    assign access_error     = result_reg.access_error;

    // With the result stalled and a word already staged, no further word may enter.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && stage_valid |-> !item_ready)
        else $error("input accepted while both stages are full");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (access_error == gce_pkg::ERR_OK
                       || access_error == gce_pkg::ERR_UNKNOWN
                       || access_error == gce_pkg::ERR_DIRECTION))
        else $error("undefined access error code");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && access_error != gce_pkg::ERR_OK |-> read_data == '0)
        else $error("failed access returned nonzero data");

    a_any_event_irq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && irq_lines[2:0] != 3'b000 |-> irq_lines[3])
        else $error("bank interrupt without the summary interrupt");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the GPIO event detect core: directed register words, then random
// reads, writes, pin changes and idle words, scored against a behavioral predictor of the register file.
// Depends on gce_pkg and gpio_controller_event_detect_core.

module testbench;

    import gce_pkg::*;

    localparam int NPINS = PIN_COUNT_DEF;
    localparam int RANDOM_WORDS = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD_AT = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 30;

    localparam logic [1:0] FUNC_IDLE = 2'd3;
    localparam logic [5:0] W_HOLE = 6'd6;
    localparam logic [5:0] W_TOP = 6'd63;
    localparam logic [31:0] BANK1_MASK = 32'((64'd1 << (NPINS - 32)) - 64'd1);

    typedef struct packed {
        logic [31:0]      rd;
        logic [3:0]       irq;
        logic [NPINS-1:0] pins;
        logic             sd;
        logic [1:0]       err;
    } outcome_t;

    typedef struct packed {
        logic [1:0]  f;
        logic [5:0]  w;
        logic [31:0] d;
        logic [5:0]  pin;
        logic        lvl;
        logic        fixed;
        logic [31:0] rd;
        logic [1:0]  err;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    logic [1:0]       func;
    logic [5:0]       reg_word;
    logic [31:0]      write_data;
    logic [5:0]       pin_index;
    logic             pin_level;
    logic             result_valid;
    logic             result_ready;
    logic [31:0]      read_data;
    logic [3:0]       irq_lines;
    logic [NPINS-1:0] pin_outputs;
    logic             sd_host_selected;
    logic [1:0]       access_error;

    // Mirror of the register file.
    logic [2:0]  pin_fn [0:NPINS-1];
    logic [31:0] out_latch [0:1];
    logic [31:0] in_level [0:1];
    logic [31:0] ev_status [0:1];
    logic [31:0] det_en [0:11];
    logic [31:0] pull_word [0:3];
    logic        sd_alt;

    outcome_t  awaited_results [$];
    stim_row_t directed_rows [$];

    int  error_count = 0;
    int  words_accepted = 0;
    int  results_checked = 0;
    int  n_reads = 0;
    int  n_writes = 0;
    int  n_pin_events = 0;
    int  cycle_count = 0;
    bit  long_hold_done = 1'b0;

    gpio_controller_event_detect_core #(
        .PIN_COUNT(NPINS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .func(func),
        .reg_word(reg_word),
        .write_data(write_data),
        .pin_index(pin_index),
        .pin_level(pin_level),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .read_data(read_data),
        .irq_lines(irq_lines),
        .pin_outputs(pin_outputs),
        .sd_host_selected(sd_host_selected),
        .access_error(access_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] bank_mask(input int b);
        return (b == 0) ? 32'hffff_ffff : BANK1_MASK;
    endfunction

    // Level seen by a bank: latch bit for output pins, external level otherwise.
    function automatic logic [31:0] bank_levels(input int b);
        logic [31:0] om;
        int p;
        om = '0;
        for (int i = 0; i < 32; i++)
        begin
            p = b * 32 + i;
            if (p < NPINS && pin_fn[p] == FSEL_OUTPUT)
                om[i] = 1'b1;
        end
        return ((out_latch[b] & om) | (in_level[b] & ~om)) & bank_mask(b);
    endfunction

    function automatic void record_events(input int b, input logic [31:0] oldl,
                                          input logic [31:0] newl);
        logic [31:0] ev;
        ev = (~oldl & newl) & (det_en[2*KIND_RISE + b] | det_en[2*KIND_ARISE + b]);
        ev |= (oldl & ~newl) & (det_en[2*KIND_FALL + b] | det_en[2*KIND_AFALL + b]);
        ev |= newl & det_en[2*KIND_HIGH + b];
        ev |= ~newl & det_en[2*KIND_LOW + b];
        ev_status[b] |= ev & bank_mask(b);
    endfunction

    function automatic void recheck_levels(input int b);
        logic [31:0] lv;
        lv = bank_levels(b);
        ev_status[b] |= ((lv & det_en[2*KIND_HIGH + b]) | (~lv & det_en[2*KIND_LOW + b]))
                        & bank_mask(b);
    endfunction

    function automatic logic [31:0] fsel_value(input int r);
        logic [31:0] v;
        int p;
        v = '0;
        for (int i = 0; i < FSEL_PER_REG; i++)
        begin
            p = r * FSEL_PER_REG + i;
            if (p < NPINS)
                v[3*i +: 3] = pin_fn[p];
        end
        return v;
    endfunction

    function automatic bit sd_group_is(input logic [2:0] code);
        bit all;
        all = 1'b1;
        for (int p = SD_FIRST_PIN; p <= SD_LAST_PIN; p++)
            if (pin_fn[p] != code)
                all = 1'b0;
        return all;
    endfunction

    function automatic void apply_fsel(input int r, input logic [31:0] v);
        logic [31:0] old0, old1;
        int p;
        old0 = bank_levels(0);
        old1 = bank_levels(1);
        for (int i = 0; i < FSEL_PER_REG; i++)
        begin
            p = r * FSEL_PER_REG + i;
            if (p < NPINS)
                pin_fn[p] = v[3*i +: 3];
        end
        if (sd_alt && sd_group_is(FSEL_INPUT))
            sd_alt = 1'b0;
        else if (!sd_alt && sd_group_is(FSEL_ALT0))
            sd_alt = 1'b1;
        record_events(0, old0, bank_levels(0));
        record_events(1, old1, bank_levels(1));
    endfunction

    function automatic void apply_latch(input int b, input logic [31:0] v, input bit set);
        logic [31:0] oldl;
        oldl = bank_levels(b);
        if (set)
            out_latch[b] |= v & bank_mask(b);
        else
            out_latch[b] &= ~(v & bank_mask(b));
        record_events(b, oldl, bank_levels(b));
    endfunction

    task automatic reset_model();
        for (int p = 0; p < NPINS; p++)
            pin_fn[p] = FSEL_INPUT;
        for (int b = 0; b < 2; b++)
        begin
            out_latch[b] = '0;
            in_level[b] = '0;
            ev_status[b] = '0;
        end
        for (int k = 0; k < 12; k++)
            det_en[k] = '0;
        pull_word[0] = PULL_RESET0;
        pull_word[1] = PULL_RESET1;
        pull_word[2] = PULL_RESET2;
        pull_word[3] = 32'(PULL_RESET3);
        sd_alt = 1'b0;
    endtask

    // Updates the mirror for one word and returns the result the core should give.
    function automatic outcome_t gpio_next_result(input logic [1:0] f, input logic [5:0] w,
                                                  input logic [31:0] d, input logic [5:0] pin,
                                                  input logic lvl);
        outcome_t o;
        int wi, kind, eb, b;
        bit en_reg, dir_latch, dir_lev, is_eds, is_pull;
        logic [31:0] oldl, ev0, ev1;
        o = '0;
        wi = w;
        en_reg = (wi >= W_REN0) && (wi <= W_AFEN1) && ((wi - W_REN0) % 3 != 2);
        kind = (wi - W_REN0) / 3;
        eb = (wi - W_REN0) % 3;
        dir_latch = (w == W_SET0) || (w == W_SET1) || (w == W_CLR0) || (w == W_CLR1);
        dir_lev = (w == W_LEV0) || (w == W_LEV1);
        is_eds = (w == W_EDS0) || (w == W_EDS1);
        is_pull = (wi >= W_PUD0) && (wi <= W_PUD3);
        if (f == FUNC_READ)
        begin
            if (wi <= W_FSEL5)
                o.rd = fsel_value(wi);
            else if (dir_latch)
                o.err = ERR_DIRECTION;
            else if (dir_lev)
                o.rd = bank_levels(wi - W_LEV0);
            else if (is_eds)
                o.rd = ev_status[wi - W_EDS0];
            else if (en_reg)
                o.rd = det_en[kind * 2 + eb];
            else if (is_pull)
                o.rd = pull_word[wi - W_PUD0];
            else
                o.err = ERR_UNKNOWN;
        end
        else if (f == FUNC_WRITE)
        begin
            if (wi <= W_FSEL5)
                apply_fsel(wi, d);
            else if (w == W_SET0 || w == W_SET1)
                apply_latch(wi - W_SET0, d, 1'b1);
            else if (w == W_CLR0 || w == W_CLR1)
                apply_latch(wi - W_CLR0, d, 1'b0);
            else if (dir_lev)
                o.err = ERR_DIRECTION;
            else if (is_eds)
            begin
                ev_status[wi - W_EDS0] &= ~d;
                recheck_levels(wi - W_EDS0);
            end
            else if (en_reg)
            begin
                det_en[kind * 2 + eb] = d & bank_mask(eb);
                if (kind == KIND_HIGH || kind == KIND_LOW)
                    recheck_levels(eb);
            end
            else if (is_pull)
            begin
                if (w == W_PUD3)
                    pull_word[3] = 32'(d[PULL3_BITS-1:0]);
                else
                    pull_word[wi - W_PUD0] = d;
            end
            else
                o.err = ERR_UNKNOWN;
        end
        else if (f == FUNC_PIN && pin < NPINS)
        begin
            b = pin >> 5;
            oldl = bank_levels(b);
            in_level[b][pin[4:0]] = lvl;
            record_events(b, oldl, bank_levels(b));
        end

        ev0 = ev_status[0];
        ev1 = ev_status[1] & BANK1_MASK;
        o.irq[0] = |(ev0 & IRQ_BANK0_MASK);
        o.irq[1] = |((ev0 & ~IRQ_BANK0_MASK) | (ev1 & IRQ_BANK1_LOW_MASK));
        o.irq[2] = |(ev1 & IRQ_BANK2_MASK);
        o.irq[3] = |(ev0 | ev1);
        for (int p = 0; p < NPINS; p++)
            o.pins[p] = (pin_fn[p] == FSEL_OUTPUT) && out_latch[p >> 5][p % 32];
        o.sd = sd_alt;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH word %0d %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
        error_count++;
    endtask

    // Offers one word; called at a falling edge and returns at a falling edge.
    task automatic offer_word(input stim_row_t row, input int gap);
        outcome_t o;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        func <= row.f;
        reg_word <= row.w;
        write_data <= row.d;
        pin_index <= row.pin;
        pin_level <= row.lvl;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        o = gpio_next_result(row.f, row.w, row.d, row.pin, row.lvl);
        if (row.fixed)
        begin
            o.rd = row.rd;
            o.err = row.err;
        end
        awaited_results.push_back(o);
        words_accepted++;
        case (row.f)
            FUNC_READ: n_reads++;
            FUNC_WRITE: n_writes++;
            FUNC_PIN: n_pin_events++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((words_accepted / 100) % 5 == 2 || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_row(input logic [1:0] f, input logic [5:0] w, input logic [31:0] d,
                           input logic [5:0] pin, input logic lvl, input logic fixed,
                           input logic [31:0] rd, input logic [1:0] err);
        directed_rows.push_back({f, w, d, pin, lvl, fixed, rd, err});
    endtask

    function automatic logic [2:0] random_fn_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return FSEL_INPUT;
        else if (r < 75)
            return FSEL_OUTPUT;
        else if (r < 85)
            return FSEL_ALT0;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int r, b;
        bit sd_push;
        logic [2:0] sd_code;
        row = '0;
        r = $urandom_range(0, 99);
        if (r < 30)
            row.f = FUNC_READ;
        else if (r < 68)
            row.f = FUNC_WRITE;
        else if (r < 97)
            row.f = FUNC_PIN;
        else
            row.f = FUNC_IDLE;
        b = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
            0: row.w = 6'($urandom_range(W_FSEL0, W_FSEL5));
            1: row.w = 6'((($urandom_range(0, 1) != 0) ? W_CLR0 : W_SET0) + b);
            2: row.w = 6'(W_LEV0 + b);
            3, 4: row.w = 6'(W_EDS0 + b);
            5, 6: row.w = 6'(W_REN0 + 3 * $urandom_range(KIND_RISE, KIND_AFALL) + b);
            default: row.w = 6'($urandom_range(W_PUD0, W_PUD3));
        endcase
        if ($urandom_range(0, 9) == 0)
            row.w = 6'($urandom_range(0, 63));
        row.d = $urandom();
        if (row.f == FUNC_WRITE)
        begin
            if (row.w <= W_FSEL5)
            begin
                // Now and then set every SD group pin in this word to one code so that routing can flip.
                sd_push = ($urandom_range(0, 3) == 0);
                sd_code = ($urandom_range(0, 1) != 0) ? FSEL_ALT0 : FSEL_INPUT;
                for (int i = 0; i < FSEL_PER_REG; i++)
                begin
                    r = row.w * FSEL_PER_REG + i;
                    if (sd_push && r >= SD_FIRST_PIN && r <= SD_LAST_PIN)
                        row.d[3*i +: 3] = sd_code;
                    else
                        row.d[3*i +: 3] = random_fn_code();
                end
            end
            else if ((row.w == W_EDS0 || row.w == W_EDS1) && $urandom_range(0, 1) != 0)
                row.d = 32'hffff_ffff;
            else if (row.w >= W_REN0 && row.w <= W_AFEN1)
            begin
                // Sparse enables keep the sticky status from saturating.
                row.d = $urandom() & $urandom() & $urandom();
                if ($urandom_range(0, 3) == 0)
                    row.d = '0;
            end
        end
        if ($urandom_range(0, 9) == 0)
            row.pin = 6'($urandom_range(NPINS, 63));
        else
            row.pin = 6'($urandom_range(0, NPINS - 1));
        row.lvl = 1'($urandom_range(0, 1));
        return row;
    endfunction

    // Result side: random stalls, calm stretches, and one long hold-off to back up the core.
    initial
    begin
        result_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && words_accepted >= LONG_HOLD_AT)
            begin
                result_ready <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else if ((words_accepted / 150) % 4 != 1 && $urandom_range(0, 99) < 35)
            begin
                result_ready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(15, 60)) @(negedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 64'(read_data), 64'd0);
            end
            else
            begin
                outcome_t e;
                e = awaited_results.pop_front();
                if (read_data !== e.rd)
                    report_mismatch("read_data", 64'(read_data), 64'(e.rd));
                if (irq_lines !== e.irq)
                    report_mismatch("irq_lines", 64'(irq_lines), 64'(e.irq));
                if (pin_outputs !== e.pins)
                    report_mismatch("pin_outputs", 64'(pin_outputs), 64'(e.pins));
                if (sd_host_selected !== e.sd)
                    report_mismatch("sd_host_selected", 64'(sd_host_selected), 64'(e.sd));
                if (access_error !== e.err)
                    report_mismatch("access_error", 64'(access_error), 64'(e.err));
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        func = FUNC_READ;
        reg_word = '0;
        write_data = '0;
        pin_index = '0;
        pin_level = 1'b0;
        reset_model();

        //      func        word     data           pin    lvl   fixed read          error
        add_row(FUNC_READ,  W_PUD0,  32'h0,         6'd0,  1'b0, 1'b1, PULL_RESET0,  ERR_OK);
        add_row(FUNC_READ,  W_PUD1,  32'h0,         6'd0,  1'b0, 1'b1, PULL_RESET1,  ERR_OK);
        add_row(FUNC_READ,  W_PUD3,  32'h0,         6'd0,  1'b0, 1'b1, 32'h0005_5555, ERR_OK);
        add_row(FUNC_READ,  W_SET0,  32'h0,         6'd0,  1'b0, 1'b1, 32'h0, ERR_DIRECTION);
        add_row(FUNC_READ,  W_CLR1,  32'h0,         6'd0,  1'b0, 1'b1, 32'h0, ERR_DIRECTION);
        add_row(FUNC_WRITE, W_LEV0,  32'hffff_ffff, 6'd0,  1'b0, 1'b1, 32'h0, ERR_DIRECTION);
        add_row(FUNC_READ,  W_HOLE,  32'h0,         6'd0,  1'b0, 1'b1, 32'h0, ERR_UNKNOWN);
        add_row(FUNC_WRITE, W_TOP,   32'hffff_ffff, 6'd0,  1'b0, 1'b1, 32'h0, ERR_UNKNOWN);
        add_row(FUNC_IDLE,  W_TOP,   32'hffff_ffff, 6'd63, 1'b1, 1'b1, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_PUD3,  32'hffff_ffff, 6'd0,  1'b0, 1'b1, 32'h0, ERR_OK);
        add_row(FUNC_READ,  W_PUD3,  32'h0,         6'd0,  1'b0, 1'b1, 32'h000f_ffff, ERR_OK);
        add_row(FUNC_WRITE, W_FSEL5, 32'hffff_ffff, 6'd0,  1'b0, 1'b1, 32'h0, ERR_OK);
        add_row(FUNC_READ,  W_FSEL5, 32'h0,         6'd0,  1'b0, 1'b1, 32'h00ff_ffff, ERR_OK);
        // Pins 48 to 53 all to ALT0 routes the SD card to the host controller.
        add_row(FUNC_WRITE, W_FSEL4, 32'h2400_0000, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_FSEL5, 32'h0000_0924, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        // Low detect on a bank that sits at zero latches every bit at once.
        add_row(FUNC_WRITE, W_LEN0,  32'hffff_ffff, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_READ,  W_EDS0,  32'h0,         6'd0,  1'b0, 1'b1, 32'hffff_ffff, ERR_OK);
        add_row(FUNC_WRITE, W_LEN0,  32'h0,         6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_EDS0,  32'hffff_ffff, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_REN1,  32'hffff_ffff, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_READ,  W_REN1,  32'h0,         6'd0,  1'b0, 1'b1, BANK1_MASK, ERR_OK);
        add_row(FUNC_PIN,   W_FSEL0, 32'h0,         6'(NPINS - 1), 1'b1, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_PIN,   W_FSEL0, 32'h0,         6'(NPINS), 1'b1, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_FSEL0, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_SET0,  32'hffff_ffff, 6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_FSEL4, 32'h0,         6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);
        add_row(FUNC_WRITE, W_FSEL5, 32'h0,         6'd0,  1'b0, 1'b0, 32'h0, ERR_OK);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer_word(directed_rows[i], sender_gap());
        for (int n = 0; n < RANDOM_WORDS; n++)
            offer_word(random_row(), sender_gap());
        item_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d words: %0d reads, %0d writes, %0d pin changes.",
                 words_accepted, n_reads, n_writes, n_pin_events);
        $display("Checked %0d result words with random stalls and one long hold-off.",
                 results_checked);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gce_pkg.sv
hw/rtl/gce_in_stage.sv
hw/rtl/gce_state.sv
hw/rtl/gpio_controller_event_detect_core.sv
test/testbench.sv
